### sv/x86_16bit_mov_add_sub_cmp_executor_assert.svh
// Assertion macros for the register execute block.
`ifndef X86_16BIT_MOV_ADD_SUB_CMP_EXECUTOR_ASSERT_SVH
`define X86_16BIT_MOV_ADD_SUB_CMP_EXECUTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define X86EXE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define X86EXE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define X86EXE_ASSERT(lbl, prop, msg)
`define X86EXE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### sv/x86exe_pkg.sv
`default_nettype none
package x86exe_pkg;

   localparam int REG_COUNT_DEFAULT   = 15;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam logic [3:0] FLAGS_INDEX = 4'd14;
   localparam logic [1:0] WORD_BYTES  = 2'd2;

   localparam int BIT_PF = 2;
   localparam int BIT_AF = 4;
   localparam int BIT_ZF = 6;
   localparam int BIT_SF = 7;

   typedef enum logic [1:0] {
      ACT_MOV = 2'd0,
      ACT_ADD = 2'd1,
      ACT_SUB = 2'd2,
      ACT_CMP = 2'd3
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [3:0]  dest_index;
      logic        dest_high_byte;
      logic [1:0]  dest_byte_count;
      logic        source_is_immediate;
      logic [3:0]  source_index;
      logic        source_high_byte;
      logic [1:0]  source_byte_count;
      logic [15:0] immediate_value;
   } req_item_type;

   typedef struct packed {
      logic [15:0] result_value;
      logic [15:0] flags_word;
      logic        result_stored;
   } rsp_item_type;

   typedef struct packed {
      logic [3:0] index;
      logic       is_word;
      logic       high;
      logic       in_range;
   } operand_type;

   typedef struct packed {
      action_type  action;
      logic        do_store;
      operand_type dest;
      operand_type src;
      logic        src_imm;
      logic [15:0] imm;
   } dec_type;

endpackage
`default_nettype wire

### sv/x86exe_ram.sv
`default_nettype none
module x86exe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule
`default_nettype wire

### sv/x86exe_fifo.sv
`default_nettype none
module x86exe_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type item_in,
   output logic     full,
   input  logic     pop,
   output item_type item_out,
   output logic     empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push_ok, pop_ok;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign item_out = mem_ff[rd_ptr_ff];
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule
`default_nettype wire

### sv/x86exe_front.sv
`default_nettype none
module x86exe_front #(
   parameter int REGISTER_COUNT = 15
) (
   input  x86exe_pkg::req_item_type req_item,
   output x86exe_pkg::dec_type      dec
);

   import x86exe_pkg::*;

   always_comb begin
      dec.action         = req_item.action;
      dec.do_store       = (req_item.action != ACT_CMP);
      dec.dest.index     = req_item.dest_index;
      dec.dest.is_word   = (req_item.dest_byte_count == WORD_BYTES);
      dec.dest.high      = req_item.dest_high_byte;
      dec.dest.in_range  = ({1'b0, req_item.dest_index} < 5'(REGISTER_COUNT));
      dec.src.index      = req_item.source_index;
      dec.src.is_word    = (req_item.source_byte_count == WORD_BYTES);
      dec.src.high       = req_item.source_high_byte;
      dec.src.in_range   = ({1'b0, req_item.source_index} < 5'(REGISTER_COUNT));
      dec.src_imm        = req_item.source_is_immediate;
      dec.imm            = req_item.immediate_value;
   end

endmodule
`default_nettype wire

### sv/x86exe_back.sv
`default_nettype none
module x86exe_back #(
   parameter int REGISTER_COUNT = 15
) (
   input  logic                     clock,
   input  logic                     reset,
   input  x86exe_pkg::dec_type      q_item,
   input  logic                     q_empty,
   output logic                     q_pop,
   output x86exe_pkg::rsp_item_type out_item,
   output logic                     out_push,
   input  logic                     out_full
);

   import x86exe_pkg::*;

   localparam int AW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

   logic        e_valid_ff, e_valid_in;
   dec_type     e_dec_ff;
   logic        hit_dst_ff, hit_dst_in;
   logic        hit_src_ff, hit_src_in;
   logic [15:0] fwd_word_ff;
   logic [15:0] flags_ff, flags_in;
   logic        valid_ff [REGISTER_COUNT];

   logic        e_fire, advance;
   logic        ram_we;
   logic [15:0] ram_dst_q, ram_src_q;
   logic [15:0] dst_full, src_full, dst, src, res, new_flags, base_flags;
   logic [15:0] old_word, merged;
   logic [4:0]  nibble;
   logic        we_ok;

   function automatic logic [15:0] pick_bytes(input logic [15:0] word, input operand_type op);
      logic [15:0] value;
      if (op.is_word) begin
         value = word;
      end else if (op.high) begin
         value = {8'h00, word[15:8]};
      end else begin
         value = {8'h00, word[7:0]};
      end
      return value;
   endfunction

   assign e_fire  = e_valid_ff && !out_full;
   assign advance = !e_valid_ff || !out_full;
   assign q_pop   = advance && !q_empty;

   always_comb begin
      if (!e_dec_ff.dest.in_range) begin
         dst_full = '0;
      end else if (e_dec_ff.dest.index == FLAGS_INDEX) begin
         dst_full = flags_ff;
      end else if (hit_dst_ff) begin
         dst_full = fwd_word_ff;
      end else if (valid_ff[e_dec_ff.dest.index[AW-1:0]]) begin
         dst_full = ram_dst_q;
      end else begin
         dst_full = '0;
      end

      if (!e_dec_ff.src.in_range) begin
         src_full = '0;
      end else if (e_dec_ff.src.index == FLAGS_INDEX) begin
         src_full = flags_ff;
      end else if (hit_src_ff) begin
         src_full = fwd_word_ff;
      end else if (valid_ff[e_dec_ff.src.index[AW-1:0]]) begin
         src_full = ram_src_q;
      end else begin
         src_full = '0;
      end

      dst = pick_bytes(dst_full, e_dec_ff.dest);
      src = e_dec_ff.src_imm ? e_dec_ff.imm : pick_bytes(src_full, e_dec_ff.src);

      unique case (e_dec_ff.action)
         ACT_MOV: begin
            res    = src;
            nibble = '0;
         end
         ACT_ADD: begin
            res    = dst + src;
            nibble = {1'b0, dst[3:0]} + {1'b0, src[3:0]};
         end
         ACT_SUB, ACT_CMP: begin
            res    = dst - src;
            nibble = {1'b0, dst[3:0]} - {1'b0, src[3:0]};
         end
         default: begin
            res    = src;
            nibble = '0;
         end
      endcase

      new_flags         = '0;
      new_flags[BIT_ZF] = (res == '0);
      new_flags[BIT_SF] = res[15];
      new_flags[BIT_PF] = ~^res[7:0];
      new_flags[BIT_AF] = nibble[4];

      base_flags = (e_dec_ff.action == ACT_MOV) ? flags_ff : new_flags;
      old_word   = (e_dec_ff.dest.index == FLAGS_INDEX) ? base_flags : dst_full;

      if (e_dec_ff.dest.is_word) begin
         merged = res;
      end else if (e_dec_ff.dest.high) begin
         merged = {res[7:0], old_word[7:0]};
      end else begin
         merged = {old_word[15:8], res[7:0]};
      end

      we_ok    = e_dec_ff.do_store && e_dec_ff.dest.in_range;
      flags_in = (we_ok && e_dec_ff.dest.index == FLAGS_INDEX) ? merged : base_flags;
      ram_we   = e_fire && we_ok && (e_dec_ff.dest.index != FLAGS_INDEX);

      e_valid_in = q_pop ? 1'b1 : (e_fire ? 1'b0 : e_valid_ff);
      hit_dst_in = e_fire && we_ok && (e_dec_ff.dest.index == q_item.dest.index);
      hit_src_in = e_fire && we_ok && (e_dec_ff.dest.index == q_item.src.index);
   end

   assign out_push              = e_fire;
   assign out_item.result_value = res;
   assign out_item.flags_word   = flags_in;
   assign out_item.result_stored = e_dec_ff.do_store;

   x86exe_ram #(
      .WIDTH (16),
      .DEPTH (REGISTER_COUNT),
      .AW    (AW)
   ) u_regs (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (e_dec_ff.dest.index[AW-1:0]),
      .wr_data   (merged),
      .rd_en     (q_pop),
      .rd_addr_a (q_item.dest.index[AW-1:0]),
      .rd_addr_b (q_item.src.index[AW-1:0]),
      .rd_data_a (ram_dst_q),
      .rd_data_b (ram_src_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         flags_ff   <= '0;
         for (int i = 0; i < REGISTER_COUNT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         e_valid_ff <= e_valid_in;
         if (e_fire) begin
            flags_ff <= flags_in;
         end
         if (ram_we) begin
            valid_ff[e_dec_ff.dest.index[AW-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         e_dec_ff    <= q_item;
         hit_dst_ff  <= hit_dst_in;
         hit_src_ff  <= hit_src_in;
         fwd_word_ff <= merged;
      end
   end

endmodule
`default_nettype wire

### sv/x86_16bit_mov_add_sub_cmp_executor.sv
`default_nettype none
// Executes decoded 8086 mov, add, sub and cmp register instructions at a sustained rate of one
// instruction per clock while the response queue is not full. The rate is set by the single
// execute stage, which starts its register file read as it takes an instruction from the queue
// and forwards the word written by the instruction just before. A short queue separates decode
// from execution and a second one holds finished responses, so request beats keep flowing while
// the response side stalls until both queues are full. The register file and flags reset to
// zero at once; there is no clearing pass.
module x86_16bit_mov_add_sub_cmp_executor #(
   parameter int REGISTER_COUNT = x86exe_pkg::REG_COUNT_DEFAULT,
   parameter int QUEUE_DEPTH    = x86exe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  x86exe_pkg::req_item_type req_item,
   output logic                     req_full,
   input  logic                     rsp_pop,
   output x86exe_pkg::rsp_item_type rsp_item,
   output logic                     rsp_empty
);

   import x86exe_pkg::*;

   dec_type      dec, q_item;
   logic         q_empty, q_pop;
   rsp_item_type out_item;
   logic         out_push, out_full;

   x86exe_front #(
      .REGISTER_COUNT (REGISTER_COUNT)
   ) u_front (
      .req_item (req_item),
      .dec      (dec)
   );

   x86exe_fifo #(
      .item_type (dec_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_dec_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .item_in  (dec),
      .full     (req_full),
      .pop      (q_pop),
      .item_out (q_item),
      .empty    (q_empty)
   );

   x86exe_back #(
      .REGISTER_COUNT (REGISTER_COUNT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_item   (q_item),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .out_item (out_item),
      .out_push (out_push),
      .out_full (out_full)
   );

   x86exe_fifo #(
      .item_type (rsp_item_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (out_push),
      .item_in  (out_item),
      .full     (out_full),
      .pop      (rsp_pop),
      .item_out (rsp_item),
      .empty    (rsp_empty)
   );

`include "x86_16bit_mov_add_sub_cmp_executor_assert.svh"

   `X86EXE_ASSERT(a_pop_needs_item, q_pop |-> !q_empty, "Execute stage took from an empty queue.")
   `X86EXE_ASSERT(a_push_kept, (req_push && !req_full && !q_pop) |=> !q_empty, "Request beat lost.")
   `X86EXE_ASSERT(a_result_kept, (out_push && !rsp_pop) |=> !rsp_empty, "Response beat lost.")
   `X86EXE_ASSERT_ALWAYS(a_reset_empty, reset |=> (rsp_empty && q_empty), "Queues not empty.")

endmodule
`default_nettype wire
